FILE: hw/rtl/powerline_command_frame_sender_assert.svh
// Assertion macros for the powerline command frame sender.
// Needs a clk and rst signal in the including module's scope.
`ifndef POWERLINE_COMMAND_FRAME_SENDER_ASSERT_SVH
`define POWERLINE_COMMAND_FRAME_SENDER_ASSERT_SVH

`ifndef SYNTH
`define PCFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PCFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCFS_ASSERT(lbl, prop, msg)
`define PCFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/pcfs_pkg.sv
// Shared types and constants for the powerline command frame sender.
// No dependencies.
package pcfs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_START,
    PH_HOUSE,
    PH_NUMBER,
    PH_TRAILER
  } pcfs_phase_t;

  localparam logic [1:0] CFG_START_PATTERN = 2'd0;
  localparam logic [1:0] CFG_BRIGHT_CODE   = 2'd1;
  localparam logic [1:0] CFG_DIM_CODE      = 2'd2;

  localparam logic [2:0] START_BITS  = 3'd4;
  localparam logic [2:0] HOUSE_BITS  = 3'd4;
  localparam logic [2:0] NUMBER_BITS = 3'd5;
  localparam logic [2:0] TRAILER_LEN = 3'd6;

  localparam logic [3:0] START_PATTERN_RST = 4'd14;
  localparam logic [4:0] BRIGHT_CODE_RST   = 5'd11;
  localparam logic [4:0] DIM_CODE_RST      = 5'd9;

  typedef struct packed {
    logic [3:0] start_pattern;
    logic [4:0] bright_code;
    logic [4:0] dim_code;
  } pcfs_cfg_t;

  typedef struct packed {
    logic carrier_burst;
    logic bit_valid;
    logic frame_done;
    logic busy_res;
    logic rejected;
  } pcfs_res_t;

endpackage

FILE: hw/rtl/pcfs_cfg.sv
// Configuration registers: start pattern, bright and dim codes.
// Depends on pcfs_pkg.
module pcfs_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  output pcfs_pkg::pcfs_cfg_t cfg
);
  import pcfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pattern <= START_PATTERN_RST;
      cfg.bright_code   <= BRIGHT_CODE_RST;
      cfg.dim_code      <= DIM_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_PATTERN: cfg.start_pattern <= cfg_data[3:0];
        CFG_BRIGHT_CODE:   cfg.bright_code   <= cfg_data;
        CFG_DIM_CODE:      cfg.dim_code      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pcfs_seq.sv
// Frame sequencer: frame state and the per-beat next-state/result logic.
// Depends on pcfs_pkg and powerline_command_frame_sender_assert.svh.
`include "powerline_command_frame_sender_assert.svh"
module pcfs_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                mode,
  input  logic [3:0]          house_addr,
  input  logic [4:0]          unit_code,
  input  logic [3:0]          repeats,
  input  pcfs_pkg::pcfs_cfg_t cfg,
  output pcfs_pkg::pcfs_res_t res
);
  import pcfs_pkg::*;

  pcfs_phase_t phase, phase_next;
  logic [2:0]  bit_index, bit_index_next;
  logic        complement_due, complement_due_next;
  logic [3:0]  repeat_left, repeat_left_next;
  logic [3:0]  house_hold, house_hold_next;
  logic [4:0]  number_hold, number_hold_next;
  logic        last_bit, last_bit_next;
  logic [2:0]  trailer_left, trailer_left_next;

  logic        trailer_due;
  logic        tx_bit;
  logic [2:0]  bi_inc;
  logic [2:0]  fld_width;
  logic [2:0]  fld_shift;
  logic [4:0]  fld_value;
  logic [4:0]  fld_shifted;
  logic [3:0]  repeat_dec;
  logic [2:0]  trailer_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_index      <= '0;
      complement_due <= 1'b0;
      repeat_left    <= '0;
      house_hold     <= '0;
      number_hold    <= '0;
      last_bit       <= 1'b0;
      trailer_left   <= '0;
    end else begin
      phase          <= phase_next;
      bit_index      <= bit_index_next;
      complement_due <= complement_due_next;
      repeat_left    <= repeat_left_next;
      house_hold     <= house_hold_next;
      number_hold    <= number_hold_next;
      last_bit       <= last_bit_next;
      trailer_left   <= trailer_left_next;
    end
  end

  // coded field shared by house and number phases
  assign fld_value   = (phase == PH_HOUSE) ? {1'b0, house_hold} : number_hold;
  assign fld_width   = (phase == PH_HOUSE) ? HOUSE_BITS : NUMBER_BITS;
  assign fld_shift   = fld_width - 3'd1 - bit_index;
  assign fld_shifted = fld_value >> fld_shift;
  assign bi_inc      = bit_index + 3'd1;
  assign repeat_dec  = repeat_left - 4'd1;
  assign trailer_dec = trailer_left - 3'd1;
  assign trailer_due = (number_hold != cfg.bright_code) && (number_hold != cfg.dim_code);

  always_comb begin
    phase_next          = phase;
    bit_index_next      = bit_index;
    complement_due_next = complement_due;
    repeat_left_next    = repeat_left;
    house_hold_next     = house_hold;
    number_hold_next    = number_hold;
    last_bit_next       = last_bit;
    trailer_left_next   = trailer_left;
    tx_bit              = 1'b0;
    res                 = '0;

    if (step) begin
      if (!mode) begin
        if (phase != PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          house_hold_next     = house_addr;
          number_hold_next    = unit_code;
          repeat_left_next    = repeats;
          bit_index_next      = '0;
          complement_due_next = 1'b0;
          last_bit_next       = 1'b0;
          trailer_left_next   = '0;
          phase_next          = PH_SYNC;
        end
      end else if (phase != PH_IDLE) begin
        res.bit_valid = 1'b1;
        unique case (phase)
          PH_SYNC: begin
            bit_index_next      = '0;
            complement_due_next = 1'b0;
            if (repeat_left != '0) begin
              phase_next = PH_START;
            end else if (trailer_due) begin
              phase_next        = PH_TRAILER;
              trailer_left_next = TRAILER_LEN;
            end else begin
              phase_next     = PH_IDLE;
              res.frame_done = 1'b1;
            end
          end
          PH_START: begin
            tx_bit = cfg.start_pattern[2'(2'd3 - bit_index[1:0])];
            if (bi_inc >= START_BITS) begin
              phase_next     = PH_HOUSE;
              bit_index_next = '0;
            end else begin
              bit_index_next = bi_inc;
            end
          end
          PH_HOUSE, PH_NUMBER: begin
            if (complement_due) begin
              tx_bit              = ~last_bit;
              complement_due_next = 1'b0;
              bit_index_next      = bi_inc;
              if (bi_inc >= fld_width) begin
                bit_index_next = '0;
                if (phase == PH_HOUSE) begin
                  phase_next = PH_NUMBER;
                end else begin
                  repeat_left_next = repeat_dec;
                  if (repeat_dec != '0) begin
                    phase_next = PH_START;
                  end else if (trailer_due) begin
                    phase_next        = PH_TRAILER;
                    trailer_left_next = TRAILER_LEN;
                  end else begin
                    phase_next     = PH_IDLE;
                    res.frame_done = 1'b1;
                  end
                end
              end
            end else begin
              tx_bit              = fld_shifted[0];
              last_bit_next       = fld_shifted[0];
              complement_due_next = 1'b1;
            end
          end
          PH_TRAILER: begin
            trailer_left_next = trailer_dec;
            if (trailer_dec == '0) begin
              phase_next     = PH_IDLE;
              res.frame_done = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    res.carrier_burst = tx_bit;
    res.busy_res      = (phase_next != PH_IDLE);
  end

  `PCFS_ASSERT(a_done_goes_idle, (step && res.frame_done) |=> (phase == PH_IDLE),
               "frame_done without return to idle")
  `PCFS_ASSERT(a_cmd_starts_sync, (step && !mode && phase == PH_IDLE) |=> (phase == PH_SYNC),
               "accepted command did not start a frame")
  `PCFS_ASSERT(a_hold_when_no_beat, !step |=> ($stable(phase) && $stable(bit_index)),
               "frame state moved without an input beat")
  `PCFS_ASSERT(a_trailer_count, (phase == PH_TRAILER) |-> (trailer_left != '0),
               "trailer phase with empty count")
  `PCFS_ASSERT(a_number_index, (phase == PH_NUMBER) |-> (bit_index < NUMBER_BITS),
               "number bit index out of range")

endmodule

FILE: hw/rtl/pcfs_out_reg.sv
// Result register on the output stream; frees the input side while it drains.
// Depends on pcfs_pkg.
module pcfs_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  pcfs_pkg::pcfs_res_t res_in,
  output logic                load_ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output pcfs_pkg::pcfs_res_t res_out
);
  import pcfs_pkg::*;

  assign load_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_ready) begin
      m_tvalid <= load;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      res_out <= res_in;
    end
  end

endmodule

FILE: hw/rtl/powerline_command_frame_sender.sv
// Top level of the powerline command frame sender (bit-level, X10-style framing).
// Depends on pcfs_pkg, pcfs_cfg, pcfs_seq, pcfs_out_reg.
//
//   port group  dir  beat contents
//   s_*         in   tuser: mode; tdata: house_addr[3:0] unit_code[8:4] repeats[12:9]
//   m_*         out  tlast: frame_done; tdata: carrier_burst bit_valid busy_res rejected
//   cfg_*       in   register write: 0 start_pattern, 1 bright_code, 2 dim_code
//
// One beat per cycle while s_tready is high; each input beat's result appears next cycle.
// Frame state advances in a single pass of next-state logic into the result register.
// s_tready drops only while a result waits and m_tready is low.
// Synchronous reset clears the frame state and loads register defaults.
module powerline_command_frame_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // house_addr[3:0], unit_code[8:4], repeats[12:9], pad
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // carrier_burst[0], bit_valid[1], busy_res[2], rejected[3]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import pcfs_pkg::*;

  pcfs_cfg_t cfg;
  pcfs_res_t res_comb;
  pcfs_res_t res_q;
  logic      step;

  assign step = s_tvalid && s_tready;

  pcfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcfs_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .mode        (s_tuser),
    .house_addr  (s_tdata[3:0]),
    .unit_code   (s_tdata[8:4]),
    .repeats     (s_tdata[12:9]),
    .cfg         (cfg),
    .res         (res_comb)
  );

  pcfs_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (s_tvalid),
    .res_in     (res_comb),
    .load_ready (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .res_out    (res_q)
  );

  assign m_tdata = {4'b0000, res_q.rejected, res_q.busy_res, res_q.bit_valid,
                    res_q.carrier_burst};
  assign m_tlast = res_q.frame_done;

endmodule

FILE: tb/tb_powerline_command_frame_sender.sv
// Self-checking testbench for powerline_command_frame_sender: command and tick beats
// go in, each result beat is checked against a bit-level frame predictor kept in step here.
// Depends on pcfs_pkg and the powerline_command_frame_sender RTL.
`timescale 1ns / 1ps

module tb_powerline_command_frame_sender;
  import pcfs_pkg::*;

  localparam logic MODE_CMD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int CHUNK_ITEMS   = 10;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic       mode;
    logic [3:0] house;
    logic [4:0] number;
    logic [3:0] repeats;
  } item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // house_addr[3:0], unit_code[8:4], repeats[12:9], pad
  logic        s_tuser = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // carrier_burst[0], bit_valid[1], busy_res[2], rejected[3]
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  powerline_command_frame_sender u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  // predictor state and register shadow
  pcfs_cfg_t   cfg_shadow;
  pcfs_phase_t frame_phase;
  logic [2:0]  bit_pos;
  logic        comp_pending;
  logic [3:0]  reps_left;
  logic [3:0]  house_latch;
  logic [4:0]  number_latch;
  logic        prev_bit;
  logic [2:0]  trail_left;

  item_t     pending_items[$];
  pcfs_res_t due_results[$];
  item_t     on_bus;
  pcfs_res_t exp_res;
  logic [7:0] exp_data;

  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycles = 0;
  int items_pushed = 0;
  int beats_in = 0;
  int beats_out = 0;
  int frames_done = 0;
  int rejects = 0;
  int bursts = 0;
  int reg_writes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("powerline_command_frame_sender: mismatch");
      $finish;
    end
  end

  // Data bit, then its complement; returns 1 once the whole field is out.
  function automatic logic coded_bit(input logic [4:0] value, input logic [2:0] w,
                                     output logic b);
    logic [2:0] sh;
    if (comp_pending) begin
      b = ~prev_bit;
      comp_pending = 1'b0;
      bit_pos = bit_pos + 3'd1;
      return bit_pos >= w;
    end
    sh = w - 3'd1 - bit_pos;
    b = 1'(value >> sh);
    prev_bit = b;
    comp_pending = 1'b1;
    return 1'b0;
  endfunction

  // Trailer unless the number code is bright or dim; returns 1 if the frame ends here.
  function automatic logic end_of_body();
    if (number_latch != cfg_shadow.bright_code && number_latch != cfg_shadow.dim_code) begin
      frame_phase = PH_TRAILER;
      trail_left = TRAILER_LEN;
      return 1'b0;
    end
    frame_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic pcfs_res_t next_frame_bit(input item_t it);
    pcfs_res_t r;
    logic b;
    r = '0;
    b = 1'b0;
    if (it.mode == MODE_CMD) begin
      if (frame_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        house_latch = it.house;
        number_latch = it.number;
        reps_left = it.repeats;
        bit_pos = '0;
        comp_pending = 1'b0;
        prev_bit = 1'b0;
        trail_left = '0;
        frame_phase = PH_SYNC;
      end
    end else if (frame_phase != PH_IDLE) begin
      r.bit_valid = 1'b1;
      case (frame_phase)
        PH_SYNC: begin
          bit_pos = '0;
          comp_pending = 1'b0;
          if (reps_left != 0) frame_phase = PH_START;
          else r.frame_done = end_of_body();
        end
        PH_START: begin
          b = cfg_shadow.start_pattern[2'(3'd3 - bit_pos)];
          bit_pos = bit_pos + 3'd1;
          if (bit_pos >= START_BITS) begin
            frame_phase = PH_HOUSE;
            bit_pos = '0;
          end
        end
        PH_HOUSE: begin
          if (coded_bit({1'b0, house_latch}, HOUSE_BITS, b)) begin
            frame_phase = PH_NUMBER;
            bit_pos = '0;
          end
        end
        PH_NUMBER: begin
          if (coded_bit(number_latch, NUMBER_BITS, b)) begin
            bit_pos = '0;
            reps_left = reps_left - 4'd1;
            if (reps_left != 0) frame_phase = PH_START;
            else r.frame_done = end_of_body();
          end
        end
        default: begin
          trail_left = trail_left - 3'd1;
          if (trail_left == 0) begin
            frame_phase = PH_IDLE;
            r.frame_done = 1'b1;
          end
        end
      endcase
      r.carrier_burst = b;
    end
    r.busy_res = (frame_phase != PH_IDLE);
    return r;
  endfunction

  // driver: predict on each accepted beat, then present the next pending item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(next_frame_bit(on_bus));
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
          on_bus = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, on_bus.repeats, on_bus.number, on_bus.house};
          s_tuser <= on_bus.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (m_tvalid && m_tready) begin
        beats_out++;
        if (due_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: tdata=%h tlast=%b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          exp_res = due_results.pop_front();
          exp_data = {4'b0000, exp_res.rejected, exp_res.busy_res, exp_res.bit_valid,
                      exp_res.carrier_burst};
          if (m_tdata !== exp_data || m_tlast !== exp_res.frame_done) begin
            $display("%0t: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                     $time, exp_data, exp_res.frame_done, m_tdata, m_tlast);
            errors++;
          end
          if (exp_res.frame_done) frames_done++;
          if (exp_res.rejected) rejects++;
          if (exp_res.carrier_burst) bursts++;
        end
      end
    end
  end

  task automatic push_item(input logic mode, input logic [3:0] house,
                           input logic [4:0] number, input logic [3:0] repeats);
    item_t it;
    it.mode = mode;
    it.house = house;
    it.number = number;
    it.repeats = repeats;
    pending_items.push_back(it);
    items_pushed++;
  endtask

  task automatic push_tick();
    push_item(MODE_TICK, 4'($urandom), 5'($urandom), 4'($urandom));
  endtask

  // one register write; the shadow follows at the edge that takes it
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_START_PATTERN: cfg_shadow.start_pattern = val[3:0];
      CFG_BRIGHT_CODE:   cfg_shadow.bright_code = val;
      default:           cfg_shadow.dim_code = val;
    endcase
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // command plus about enough ticks to finish it, with stray commands and early cut-offs
  task automatic gen_frame(input bit long_frame);
    logic [4:0] num;
    logic [3:0] reps;
    logic [3:0] house;
    int n;
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) num = cfg_shadow.bright_code;
    else if (sel < 5) num = cfg_shadow.dim_code;
    else if (sel == 5) num = 5'd0;
    else if (sel == 6) num = 5'd31;
    else num = 5'($urandom);
    sel = $urandom_range(5);
    house = (sel == 0) ? 4'd0 : (sel == 1) ? 4'd15 : 4'($urandom);
    if (long_frame) reps = 4'd15;
    else if ($urandom_range(9) == 0) reps = 4'($urandom_range(3, 4));
    else reps = 4'($urandom_range(0, 2));
    push_item(MODE_CMD, house, num, reps);
    n = 1 + 22 * reps;
    if (num != cfg_shadow.bright_code && num != cfg_shadow.dim_code) n += 6;
    if (!long_frame && $urandom_range(9) == 0) n = $urandom_range(1, n);
    n += $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4)
        push_item(MODE_CMD, 4'($urandom), 5'($urandom), 4'($urandom));
      else
        push_tick();
    end
  endtask

  initial begin
    logic [4:0] bright;
    int chunk;
    int chunk_start;
    cfg_shadow.start_pattern = START_PATTERN_RST;
    cfg_shadow.bright_code = BRIGHT_CODE_RST;
    cfg_shadow.dim_code = DIM_CODE_RST;
    frame_phase = PH_IDLE;
    bit_pos = '0;
    comp_pending = 1'b0;
    reps_left = '0;
    house_latch = '0;
    number_latch = '0;
    prev_bit = 1'b0;
    trail_left = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    gap_pct = 6;
    stall_pct = 88;

    // directed: idle tick, bright and dim with no repeats, full trailer with a
    // command rejected mid-frame, then a tick after the frame ended
    push_tick();
    push_item(MODE_CMD, 4'd15, BRIGHT_CODE_RST, 4'd0);
    push_tick();
    push_item(MODE_CMD, 4'd0, DIM_CODE_RST, 4'd0);
    push_tick();
    push_item(MODE_CMD, 4'd5, 5'd0, 4'd0);
    push_item(MODE_CMD, 4'd15, 5'd31, 4'd15);
    repeat (7) push_tick();
    push_tick();
    wait_drain();

    chunk = 0;
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin gap_pct = 6;  stall_pct = 88; end
        1: begin gap_pct = 88; stall_pct = 6;  end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (int c = 0; c < 3; c++) begin
        // frames may be left running across these writes on purpose
        case (chunk % 3)
          0: begin
            write_reg(CFG_START_PATTERN, {1'b1, 4'd0});
            write_reg(CFG_BRIGHT_CODE, 5'd0);
            write_reg(CFG_DIM_CODE, 5'd31);
          end
          1: begin
            write_reg(CFG_START_PATTERN, {1'b0, 4'd15});
            write_reg(CFG_BRIGHT_CODE, 5'd31);
            write_reg(CFG_DIM_CODE, 5'd0);
          end
          default: begin
            bright = 5'($urandom);
            write_reg(CFG_START_PATTERN, 5'($urandom));
            write_reg(CFG_BRIGHT_CODE, bright);
            write_reg(CFG_DIM_CODE, ($urandom_range(3) == 0) ? bright : 5'($urandom));
          end
        endcase
        @(negedge clk);
        chunk_start = items_pushed;
        if (stage == 2 && c == 1) gen_frame(1'b1);
        while (items_pushed - chunk_start < CHUNK_ITEMS) gen_frame(1'b0);
        wait_drain();
        chunk++;
      end
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Ran %0d input beats and %0d result beats over %0d register settings.",
             beats_in, beats_out, chunk + 1);
    $display("Saw %0d completed frames, %0d rejected commands, %0d carrier bursts.",
             frames_done, rejects, bursts);
    if (errors == 0 && due_results.size() == 0) begin
      $display("powerline_command_frame_sender: match");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, due_results.size());
      $display("powerline_command_frame_sender: mismatch");
    end
    $finish;
  end

endmodule
